>>> design/rds_pkg.sv
// Shared types and constants for the reliable datagram sequencer.
package rds_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] KIND_SEND   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] RES_SEND   = 2'd0;
    localparam logic [1:0] RES_RESEND = 2'd1;
    localparam logic [1:0] RES_ACK    = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_UNREL    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] CH_UNREL   = 2'd0;
    localparam logic [1:0] CH_SEQ     = 2'd1;
    localparam logic [1:0] CH_REL     = 2'd2;
    localparam logic [1:0] CH_ORDERED = 2'd3;

    localparam logic [2:0] TAG_UNREL   = 3'd0;
    localparam logic [2:0] TAG_SEQ     = 3'd1;
    localparam logic [2:0] TAG_REL     = 3'd2;
    localparam logic [2:0] TAG_ORDERED = 3'd4;

    localparam logic [15:0] DELAY_RESET = 16'd50;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [63:0] ack_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [2:0]  header_tag;
        logic        has_sequence;
        logic [63:0] sequence_res;
        logic [1:0]  status;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACK_SCAN,
        S_ACK_SHIFT,
        S_TICK_SCAN
    } t_state;

endpackage

>>> design/reliable_datagram_sequencer.sv
// Top level of the reliable datagram sequencer.
// A send or an ack on an unreliable channel is registered in the front-end
// queue and then in the back end's result register; an ack walks the
// pending table one entry per cycle, first to find the id and then to
// close the gap; a tick scans both tables one entry per cycle, emitting at
// most one resend per cycle. Those table walks in the back end set the
// rate. A two-entry queue stands in front, so busy rises while it is full
// and while reset is held. Results appear for a single cycle on o_strobe and
// cannot be held off; the last result of a transaction carries last.
module reliable_datagram_sequencer #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rds_pkg::t_in  i_item,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    output logic          o_strobe,
    output rds_pkg::t_out o_result
);
    logic         q_valid, q_pop;
    rds_pkg::t_in q_item;

    rds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    rds_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );
endmodule

>>> design/rds_front.sv
// Front end: accepts transactions, drops unused kinds, two-entry queue.
module rds_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rds_pkg::t_in  i_item,
    output logic          busy,
    input  logic          i_pop,
    output logic          o_valid,
    output rds_pkg::t_in  o_item
);
    rds_pkg::t_in r_q [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign busy    = (r_cnt == 2'd2) || !i_rst_n;
    // kind three carries no work and is discarded here
    assign push    = start && !busy && (i_item.kind != rds_pkg::KIND_UNUSED);
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = i_pop && o_valid;
    assign o_item  = r_q[r_rp];

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
    end
endmodule

>>> design/rds_back.sv
// Back end: sequence counters, pending tables, ack search and tick scan.
module rds_back #(
    parameter int PENDING_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_valid,
    input  rds_pkg::t_in  i_item,
    output logic          o_pop,
    output logic          o_strobe,
    output rds_pkg::t_out o_result
);
    localparam int IW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(PENDING_DEPTH);
    localparam logic [rds_pkg::K_W-1:0] MAX_C = rds_pkg::K_W'(rds_pkg::MAX_RESULTS);

    rds_pkg::t_state r_state, n_state;
    logic [15:0]   r_delay;
    logic [63:0]   r_seq_s, n_seq_s, r_seq_r, n_seq_r, r_seq_o, n_seq_o;
    logic [31:0]   r_time, n_time;
    logic [CW-1:0] r_cnt [2];
    logic [CW-1:0] n_cnt [2];
    logic [CW-1:0] r_j, n_j, nj;
    logic          r_t, n_t;
    logic [rds_pkg::K_W-1:0] r_k, n_k;
    logic [63:0]   r_ack, n_ack;
    logic          r_hold_v, n_hold_v;
    rds_pkg::t_out r_hold, n_hold, r_out, n_out;
    logic          r_stb, n_stb;

    logic [63:0]   r_pid   [2][PENDING_DEPTH];
    logic [31:0]   r_pstamp[2][PENDING_DEPTH];
    logic          wr_en, wr_t;
    logic [IW-1:0] wr_idx;
    logic [63:0]   wr_id;
    logic [31:0]   wr_stamp;
    logic [CW-1:0] rd_idx;
    logic [63:0]   rd_id;
    logic [31:0]   rd_stamp, age;
    logic          tsel;
    logic [2:0]    ttag;

    assign nj       = r_j + 1'b1;
    assign rd_idx   = (r_state == rds_pkg::S_ACK_SHIFT) ? nj : r_j;
    assign rd_id    = r_pid[r_t][rd_idx[IW-1:0]];
    assign rd_stamp = r_pstamp[r_t][rd_idx[IW-1:0]];
    assign age      = r_time - rd_stamp;
    assign tsel     = i_item.channel[0];
    assign ttag     = r_t ? rds_pkg::TAG_ORDERED : rds_pkg::TAG_REL;
    assign o_pop    = (r_state == rds_pkg::S_IDLE);
    assign o_strobe = r_stb;
    assign o_result = r_out;

    // next state and outputs
    always_comb begin
        n_state  = r_state;
        n_seq_s  = r_seq_s;
        n_seq_r  = r_seq_r;
        n_seq_o  = r_seq_o;
        n_time   = r_time;
        n_cnt    = r_cnt;
        n_j      = r_j;
        n_t      = r_t;
        n_k      = r_k;
        n_ack    = r_ack;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_out    = r_out;
        n_stb    = 1'b0;
        wr_en    = 1'b0;
        wr_t     = r_t;
        wr_idx   = r_j[IW-1:0];
        wr_id    = rd_id;
        wr_stamp = rd_stamp;
        unique case (r_state)
            rds_pkg::S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.kind)
                        rds_pkg::KIND_SEND: begin
                            n_stb = 1'b1;
                            n_out = '{rds_pkg::RES_SEND, rds_pkg::TAG_UNREL, 1'b0,
                                      64'd0, rds_pkg::ST_OK, 1'b1};
                            if (i_item.channel == rds_pkg::CH_UNREL) begin
                            end else if (i_item.channel == rds_pkg::CH_SEQ) begin
                                n_out.header_tag   = rds_pkg::TAG_SEQ;
                                n_out.has_sequence = 1'b1;
                                n_out.sequence_res = r_seq_s;
                                n_seq_s            = r_seq_s + 64'd1;
                            end else begin
                                n_out.header_tag   = tsel ? rds_pkg::TAG_ORDERED
                                                          : rds_pkg::TAG_REL;
                                n_out.has_sequence = 1'b1;
                                n_out.sequence_res = tsel ? r_seq_o : r_seq_r;
                                if (tsel) n_seq_o = r_seq_o + 64'd1;
                                else      n_seq_r = r_seq_r + 64'd1;
                                if (r_cnt[tsel] < DEPTH_C) begin
                                    wr_en       = 1'b1;
                                    wr_t        = tsel;
                                    wr_idx      = r_cnt[tsel][IW-1:0];
                                    wr_id       = n_out.sequence_res;
                                    wr_stamp    = r_time;
                                    n_cnt[tsel] = r_cnt[tsel] + 1'b1;
                                end else begin
                                    n_out.status = rds_pkg::ST_FULL;
                                end
                            end
                        end
                        rds_pkg::KIND_ACK: begin
                            if (i_item.channel == rds_pkg::CH_UNREL ||
                                i_item.channel == rds_pkg::CH_SEQ) begin
                                n_stb = 1'b1;
                                n_out = '{rds_pkg::RES_ACK, rds_pkg::TAG_UNREL, 1'b0,
                                          i_item.ack_id, rds_pkg::ST_UNREL, 1'b1};
                            end else begin
                                n_t     = tsel;
                                n_j     = '0;
                                n_ack   = i_item.ack_id;
                                n_state = rds_pkg::S_ACK_SCAN;
                            end
                        end
                        rds_pkg::KIND_TICK: begin
                            n_time   = r_time + 32'd1;
                            n_t      = 1'b0;
                            n_j      = '0;
                            n_k      = '0;
                            n_hold_v = 1'b0;
                            n_state  = rds_pkg::S_TICK_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // linear search for the oldest matching id
            rds_pkg::S_ACK_SCAN: begin
                if (r_j == r_cnt[r_t]) begin
                    n_stb   = 1'b1;
                    n_out   = '{rds_pkg::RES_ACK, rds_pkg::TAG_UNREL, 1'b0,
                                r_ack, rds_pkg::ST_NOTFOUND, 1'b1};
                    n_state = rds_pkg::S_IDLE;
                end else if (rd_id == r_ack) begin
                    n_state = rds_pkg::S_ACK_SHIFT;
                end else begin
                    n_j = nj;
                end
            end
            // close the gap, one entry per cycle
            rds_pkg::S_ACK_SHIFT: begin
                if (nj < r_cnt[r_t]) begin
                    wr_en = 1'b1;
                    n_j   = nj;
                end else begin
                    n_cnt[r_t] = r_cnt[r_t] - 1'b1;
                    n_stb      = 1'b1;
                    n_out      = '{rds_pkg::RES_ACK, rds_pkg::TAG_UNREL, 1'b0,
                                   r_ack, rds_pkg::ST_OK, 1'b1};
                    n_state    = rds_pkg::S_IDLE;
                end
            end
            // resend scan; one result held back so the final one gets last
            rds_pkg::S_TICK_SCAN: begin
                if (r_j < r_cnt[r_t] && r_k < MAX_C) begin
                    if (age >= {16'd0, r_delay}) begin
                        if (r_hold_v) begin
                            n_stb = 1'b1;
                            n_out = r_hold;
                        end
                        n_hold   = '{rds_pkg::RES_RESEND, ttag, 1'b1, rd_id,
                                     rds_pkg::ST_OK, 1'b0};
                        n_hold_v = 1'b1;
                        n_k      = r_k + 1'b1;
                    end
                    n_j = nj;
                end else if (!r_t) begin
                    n_t = 1'b1;
                    n_j = '0;
                end else begin
                    if (r_hold_v) begin
                        n_stb      = 1'b1;
                        n_out      = r_hold;
                        n_out.last = 1'b1;
                    end
                    n_hold_v = 1'b0;
                    n_state  = rds_pkg::S_IDLE;
                end
            end
            default: n_state = rds_pkg::S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rds_pkg::S_IDLE;
            r_delay  <= rds_pkg::DELAY_RESET;
            r_seq_s  <= '0;
            r_seq_r  <= '0;
            r_seq_o  <= '0;
            r_time   <= '0;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_stb    <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) r_delay <= i_cfg_data;
            r_seq_s  <= n_seq_s;
            r_seq_r  <= n_seq_r;
            r_seq_o  <= n_seq_o;
            r_time   <= n_time;
            r_cnt    <= n_cnt;
            r_stb    <= n_stb;
            r_hold_v <= n_hold_v;
        end
    end

    // payload registers and pending tables
    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_t    <= n_t;
        r_k    <= n_k;
        r_ack  <= n_ack;
        r_hold <= n_hold;
        r_out  <= n_out;
        if (wr_en) begin
            r_pid[wr_t][wr_idx]    <= wr_id;
            r_pstamp[wr_t][wr_idx] <= wr_stamp;
        end
    end
endmodule

>>> design/rds_checker.sv
// Port-level assertions for the reliable datagram sequencer, with bind.
module rds_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          busy,
    input logic          o_strobe,
    input rds_pkg::t_out o_result
);
    // no result in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("result right after reset");

    // fresh sends and ack statuses are single results
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.result_kind == rds_pkg::RES_SEND ||
                     o_result.result_kind == rds_pkg::RES_ACK) |-> o_result.last)
        else $error("single result without last");

    // ack results carry no header
    a_ack_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.result_kind == rds_pkg::RES_ACK
        |-> o_result.header_tag == rds_pkg::TAG_UNREL && !o_result.has_sequence)
        else $error("ack result with header");

    // resends only come from reliable tables
    a_resend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.result_kind == rds_pkg::RES_RESEND
        |-> (o_result.header_tag == rds_pkg::TAG_REL ||
             o_result.header_tag == rds_pkg::TAG_ORDERED) &&
            o_result.status == rds_pkg::ST_OK)
        else $error("bad resend");

    // busy is held during reset
    a_busy_rst: assert property (@(posedge i_clk) !i_rst_n |-> busy)
        else $error("not busy in reset");
endmodule

bind reliable_datagram_sequencer rds_checker u_rds_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
